// ----- sv/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

	// width of every operand and result field on the ports
	localparam int FIELD_W = 32;

	// default internal operand width
	localparam int WIDTH_DEFAULT = 32;

endpackage

// ----- sv/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus by left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
// One beat at a time: the request side stalls from acceptance until the result
// has moved into the output register, which can still hold the previous result
// while the next beat is accepted. All work runs through one bit-serial modular
// multiplier. An item takes one product to reduce the base, one squaring per
// exponent bit and one multiply per set bit. A zero modulus skips all work,
// flags modulus_error and returns 0.
module modular_exponentiation #(
	parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [mexp_pkg::FIELD_W-1:0]  base,
	input  logic [mexp_pkg::FIELD_W-1:0]  exponent,
	input  logic [mexp_pkg::FIELD_W-1:0]  modulus,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [mexp_pkg::FIELD_W-1:0]  power_residue,
	output logic                          modulus_error
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic               start_q;
	logic [WIDTH-1:0]   m_q;
	logic [WIDTH-1:0]   exp_q;
	logic [WIDTH-1:0]   base_q;
	logic [WIDTH-1:0]   bred_q;
	logic [WIDTH-1:0]   acc_q;
	logic [CNT_W-1:0]   ecnt_q;
	logic               err_q;
	logic               rsp_valid_q;
	logic [FIELD_W-1:0] residue_q;
	logic               error_q;

	logic [WIDTH-1:0]   base_in;
	logic [WIDTH-1:0]   exp_in;
	logic [WIDTH-1:0]   mod_in;
	logic [WIDTH-1:0]   mul_b;
	logic [WIDTH-1:0]   mul_p;
	logic               mul_done;

	assign base_in = WIDTH'(base);
	assign exp_in  = WIDTH'(exponent);
	assign mod_in  = WIDTH'(modulus);

	// multiplicand is always the accumulator; during the base reduction it
	// holds 1 mod m, so Horner over the base bits yields base mod m
	always_comb begin
		case (state_q)
			ST_REDUCE: mul_b = base_q;
			ST_SQUARE: mul_b = acc_q;
			ST_MULT:   mul_b = bred_q;
			default:   mul_b = acc_q;
		endcase
	end

	mexp_mulmod #(
		.WIDTH(WIDTH)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.a       (acc_q),
		.b       (mul_b),
		.m       (m_q),
		.done    (mul_done),
		.product (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			m_q         <= '0;
			exp_q       <= '0;
			base_q      <= '0;
			bred_q      <= '0;
			acc_q       <= '0;
			ecnt_q      <= '0;
			err_q       <= 1'b0;
			residue_q   <= '0;
			error_q     <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						m_q    <= mod_in;
						exp_q  <= exp_in;
						base_q <= base_in;
						if (mod_in == '0) begin
							err_q   <= 1'b1;
							acc_q   <= '0;
							state_q <= ST_FINISH;
						end else begin
							err_q   <= 1'b0;
							acc_q   <= {{(WIDTH-1){1'b0}}, mod_in != WIDTH'(1)};
							start_q <= 1'b1;
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (mul_done) begin
						bred_q  <= mul_p;
						ecnt_q  <= CNT_W'(WIDTH - 1);
						start_q <= 1'b1;
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (mul_done) begin
						acc_q <= mul_p;
						if (exp_q[WIDTH-1]) begin
							start_q <= 1'b1;
							state_q <= ST_MULT;
						end else if (ecnt_q == '0) begin
							state_q <= ST_FINISH;
						end else begin
							ecnt_q  <= ecnt_q - 1'b1;
							exp_q   <= exp_q << 1;
							start_q <= 1'b1;
						end
					end
				end
				ST_MULT: begin
					if (mul_done) begin
						acc_q <= mul_p;
						if (ecnt_q == '0) begin
							state_q <= ST_FINISH;
						end else begin
							ecnt_q  <= ecnt_q - 1'b1;
							exp_q   <= exp_q << 1;
							start_q <= 1'b1;
							state_q <= ST_SQUARE;
						end
					end
				end
				ST_FINISH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						residue_q   <= FIELD_W'(acc_q);
						error_q     <= err_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall     = (state_q != ST_IDLE);
	assign rsp_valid     = rsp_valid_q;
	assign power_residue = residue_q;
	assign modulus_error = error_q;

endmodule

// ----- sv/mexp_mulmod.sv -----
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: product = (a * b) mod m by double-and-add,
// one bit of b per cycle, MSB first. Requires a < m and m != 0.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
	parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] m,
	output logic             done,
	output logic [WIDTH-1:0] product
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+1:0] m1;
	logic [WIDTH+1:0] m2;
	logic [WIDTH+1:0] red;

	// 2*acc + bit*a stays below 3m, so at most two subtractions of m
	always_comb begin
		m1  = {2'b00, m};
		m2  = {1'b0, m, 1'b0};
		sum = {1'b0, acc_q, 1'b0} + (b_q[WIDTH-1] ? {2'b00, a_q} : '0);
		if (sum >= m2) begin
			red = sum - m2;
		end else if (sum >= m1) begin
			red = sum - m1;
		end else begin
			red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= red[WIDTH-1:0];
			b_q   <= b_q << 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- sv/mexp_checker.sv -----
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks for the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_stall,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input logic [mexp_pkg::FIELD_W-1:0] power_residue,
	input logic                         modulus_error
);
	import mexp_pkg::*;

	// an error beat always carries a zero residue
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && modulus_error |-> power_residue == '0)
		else $error("error beat with nonzero residue");

	// one item at a time: accepting a beat closes the request side
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side open right after accept");

	// no result can appear the cycle right after an accept
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !$rose(rsp_valid))
		else $error("result appeared too early");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(power_residue)
			&& $stable(modulus_error))
		else $error("stalled result beat changed");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req_valid),
	.req_stall     (req_stall),
	.rsp_valid     (rsp_valid),
	.rsp_stall     (rsp_stall),
	.power_residue (power_residue),
	.modulus_error (modulus_error)
);

// ----- tb/modular_exponentiation_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the modular exponentiation block. Directed corner
// beats (zero and unit modulus, zero exponent and base, all-ones operands)
// are followed by a few hundred random beats. Every accepted request is
// predicted by a plain square-and-multiply model. Each response is checked
// in order, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

	import mexp_pkg::*;

	localparam int N_RANDOM    = 252;
	localparam int N_PLANNED   = N_RANDOM + 25;
	// one beat: base reduction, a squaring per exponent bit, a multiply per set bit
	localparam int ITEM_CYCLES = (FIELD_W + 2) * (1 + 2 * FIELD_W) + 3;
	localparam longint LIMIT   = longint'(N_PLANNED) * (ITEM_CYCLES + 16) * 4 + 1000;

	typedef logic [FIELD_W-1:0] word_t;

	typedef struct {
		word_t       base;
		word_t       exponent;
		word_t       modulus;
		int unsigned idle;
		bit          drain_first;
	} req_beat_t;

	typedef struct {
		word_t value;
		logic  err;
	} residue_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	word_t base = '0;
	word_t exponent = '0;
	word_t modulus = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	word_t power_residue;
	logic  modulus_error;

	req_beat_t   pend_q[$];
	residue_t    residue_q[$];
	int unsigned idle_cnt = 0;
	int unsigned stall_left = 0;
	int unsigned rsp_hold;
	bit          req_calm = 1'b0;
	bit          rsp_calm = 1'b0;
	int          err_count = 0;
	longint      cycle_cnt = 0;
	residue_t    got;
	residue_t    want;

	modular_exponentiation u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.base          (base),
		.exponent      (exponent),
		.modulus       (modulus),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.power_residue (power_residue),
		.modulus_error (modulus_error)
	);

	always #5 clk = ~clk;

	// operands fit in 32 bits, so 64-bit products never overflow
	function automatic residue_t predict_residue(input word_t b, input word_t e, input word_t m);
		residue_t      r;
		bit [63:0]     acc;
		bit [63:0]     bb;
		bit [63:0]     mm;
		if (m == '0) begin
			r.value = '0;
			r.err   = 1'b1;
			return r;
		end
		mm  = 64'(m);
		bb  = 64'(b) % mm;
		acc = 64'd1 % mm;
		for (int i = FIELD_W - 1; i >= 0; i--) begin
			acc = (acc * acc) % mm;
			if (e[i])
				acc = (acc * bb) % mm;
		end
		r.value = acc[FIELD_W-1:0];
		r.err   = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input word_t exp_val, input word_t got_val);
		$display("MISMATCH %s: expected %h got %h at %0t", what, exp_val, got_val, $realtime);
		err_count++;
	endtask

	task automatic queue_beat(input word_t b, input word_t e, input word_t m, input bit drain);
		req_beat_t beat;
		if ($urandom_range(0, 15) == 0)
			req_calm = !req_calm;
		beat.base        = b;
		beat.exponent    = e;
		beat.modulus     = m;
		beat.idle        = req_calm ? 0 : $urandom_range(0, 7);
		beat.drain_first = drain;
		pend_q.push_back(beat);
	endtask

	task automatic queue_random_beat(input bit drain);
		word_t m;
		word_t e;
		word_t b;
		case ($urandom_range(0, 15))
			0:       m = '0;
			1:       m = word_t'(1);
			2, 3:    m = word_t'($urandom_range(2, 255));
			4, 5:    m = word_t'($urandom) | {1'b1, {(FIELD_W-1){1'b0}}};
			default: m = word_t'($urandom);
		endcase
		case ($urandom_range(0, 15))
			0:       e = '0;
			1:       e = '1;
			2, 3:    e = word_t'($urandom_range(1, 16));
			default: e = word_t'($urandom);
		endcase
		case ($urandom_range(0, 15))
			0:       b = '0;
			1:       b = '1;
			2:       b = m;
			3:       b = (m != '0) ? word_t'($urandom) % m : word_t'($urandom);
			default: b = word_t'($urandom);
		endcase
		queue_beat(b, e, m, drain);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			base      <= '0;
			exponent  <= '0;
			modulus   <= '0;
			idle_cnt  <= 0;
		end else begin
			if (req_valid && !req_stall)
				residue_q.push_back(predict_residue(base, exponent, modulus));
			if (!(req_valid && req_stall)) begin
				if (pend_q.size() == 0) begin
					req_valid <= 1'b0;
				end else if (idle_cnt < pend_q[0].idle) begin
					idle_cnt  <= idle_cnt + 1;
					req_valid <= 1'b0;
				end else if (pend_q[0].drain_first && (residue_q.size() != 0 || rsp_valid)) begin
					req_valid <= 1'b0;
				end else begin
					base      <= pend_q[0].base;
					exponent  <= pend_q[0].exponent;
					modulus   <= pend_q[0].modulus;
					req_valid <= 1'b1;
					idle_cnt  <= 0;
					void'(pend_q.pop_front());
				end
			end
		end
	end

	// response monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got.value = power_residue;
				got.err   = modulus_error;
				if (residue_q.size() == 0) begin
					report_mismatch("response beat with nothing pending", '0, got.value);
				end else begin
					want = residue_q.pop_front();
					if (got.value !== want.value)
						report_mismatch("power_residue", want.value, got.value);
					if (got.err !== want.err)
						report_mismatch("modulus_error", word_t'(want.err), word_t'(got.err));
				end
				if ($urandom_range(0, 15) == 0)
					rsp_calm = !rsp_calm;
				rsp_hold = rsp_calm ? 0 : $urandom_range(0, 7);
				stall_left <= rsp_hold;
				rsp_stall  <= (rsp_hold != 0);
			end else if (rsp_valid && stall_left != 0) begin
				stall_left <= stall_left - 1;
				rsp_stall  <= (stall_left != 1);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		// zero modulus flags an error regardless of operands
		queue_beat(word_t'(5), word_t'(3), '0, 1'b0);
		queue_beat('1, '1, '0, 1'b0);
		queue_beat('0, '0, '0, 1'b0);
		// unit modulus always gives zero
		queue_beat('1, '1, word_t'(1), 1'b0);
		queue_beat(word_t'(7), '0, word_t'(1), 1'b0);
		// zero exponent gives one
		queue_beat(word_t'(12345), '0, word_t'(1000), 1'b0);
		queue_beat('0, '0, '1, 1'b0);
		// zero base with nonzero exponent, then mixed operand beats
		queue_beat('0, word_t'(1), word_t'(97), 1'b0);
		queue_beat('0, '1, '1, 1'b0);
		queue_beat('1, '1, '1, 1'b0);
		queue_beat('1, word_t'(1), '1, 1'b1);
		queue_beat(word_t'(1000), word_t'(2), word_t'(7), 1'b0);
		queue_beat(word_t'(3), '1, word_t'(2), 1'b0);
		queue_beat(word_t'(2), word_t'(32'hFFFF_FFFA), word_t'(32'hFFFF_FFFB), 1'b0);
		queue_beat(word_t'(32'h8000_0001), word_t'(32'h5555_5555), word_t'(32'h8000_0000), 1'b0);
		queue_beat(word_t'(1), word_t'(32'hAAAA_AAAA), word_t'(32'h7FFF_FFFF), 1'b0);
		queue_beat(word_t'(97), word_t'(5), word_t'(97), 1'b0);
		queue_beat(word_t'(32'hDEAD_BEEF), word_t'(32'h0001_0001), word_t'(32'hFFFF_FFF1), 1'b0);
		for (int i = 0; i < N_RANDOM; i++)
			queue_random_beat(i % 50 == 25);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(posedge clk);
		while (pend_q.size() != 0 || req_valid || residue_q.size() != 0);
		// catch any stray beat after the last expected one
		repeat (ITEM_CYCLES + 16) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
sv/mexp_pkg.sv
sv/mexp_mulmod.sv
sv/modular_exponentiation.sv
sv/mexp_checker.sv
tb/modular_exponentiation_tb.sv
